>>> hw/rtl/tss_pkg.sv
`timescale 1ns / 1ps

package tss_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 6;

    typedef struct packed {
        logic signed [DATA_W-1:0] lower;
        logic signed [DATA_W-1:0] diag;
        logic signed [DATA_W-1:0] upper;
        logic signed [DATA_W-1:0] rhs;
        logic                     last;
        logic [IDX_W-1:0]         idx;
    } t_row;

    // front queue to back sequencer
    typedef struct packed {
        logic valid;
        t_row row;
    } t_queue_head;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_START,
        ST_DIV,
        ST_STORE,
        ST_OUT,
        ST_READ,
        ST_BMUL,
        ST_BADD
    } t_state;

    // saturate a wide sum to 32 bits; MSB of the result flags overflow
    function automatic logic [DATA_W:0] sat_wide(input logic signed [64:0] v);
        logic [DATA_W:0] res;
        if (v > 65'sd2147483647) begin
            res = {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
        end else if (v < -65'sd2147483648) begin
            res = {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            res = {1'b0, v[DATA_W-1:0]};
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/tss_if.sv
`timescale 1ns / 1ps

interface tss_row_if;
    logic                                valid;
    logic                                ready;
    logic signed [tss_pkg::DATA_W-1:0]   lower_coeff;
    logic signed [tss_pkg::DATA_W-1:0]   diag_coeff;
    logic signed [tss_pkg::DATA_W-1:0]   upper_coeff;
    logic signed [tss_pkg::DATA_W-1:0]   rhs_value;
    logic                                last_row;

    modport source (output valid, lower_coeff, diag_coeff, upper_coeff, rhs_value, last_row,
                    input ready);
    modport sink   (input valid, lower_coeff, diag_coeff, upper_coeff, rhs_value, last_row,
                    output ready);
endinterface

interface tss_sol_if;
    logic                                valid;
    logic                                ready;
    logic signed [tss_pkg::DATA_W-1:0]   solution_value;
    logic [tss_pkg::IDX_W-1:0]           solution_index;
    logic                                pivot_error;
    logic                                last_result;

    modport source (output valid, solution_value, solution_index, pivot_error, last_result,
                    input ready);
    modport sink   (input valid, solution_value, solution_index, pivot_error, last_result,
                    output ready);
endinterface

>>> hw/rtl/tss_front.sv
`timescale 1ns / 1ps

module tss_front #(
    parameter int MAX_ROWS = tss_pkg::MAX_ROWS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tss_row_if.sink               i_row,
    output tss_pkg::t_queue_head  o_head,
    input  logic                  i_pop
);

    localparam int AW = $clog2(MAX_ROWS);
    localparam int IW = tss_pkg::IDX_W;

    logic [AW-1:0]  r_idx;
    tss_pkg::t_row  r_buf [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           w_accept;
    logic           w_last;
    tss_pkg::t_row  w_row;

    assign i_row.ready = (r_cnt != 2'd2);
    assign w_accept    = i_row.valid && i_row.ready;
    // a full system forces the last row
    assign w_last      = i_row.last_row || (r_idx == AW'(MAX_ROWS - 1));

    always_comb begin
        w_row.lower = i_row.lower_coeff;
        w_row.diag  = i_row.diag_coeff;
        w_row.upper = i_row.upper_coeff;
        w_row.rhs   = i_row.rhs_value;
        w_row.last  = w_last;
        w_row.idx   = IW'(r_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_accept) begin
                r_wp  <= ~r_wp;
                r_idx <= w_last ? '0 : r_idx + 1'b1;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_accept} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_buf[r_wp] <= w_row;
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.row   = r_buf[r_rp];

endmodule

>>> hw/rtl/tss_div.sv
`timescale 1ns / 1ps

module tss_div #(
    parameter int DW = tss_pkg::DATA_W + tss_pkg::FRAC_BITS,
    parameter int VW = tss_pkg::DATA_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [VW-1:0] r_rem;
    logic [DW-1:0] r_dvd;
    logic [VW-1:0] r_dvs;
    logic [VW:0]   w_trial;
    logic          w_fit;

    // restoring step: one quotient bit per cycle
    assign w_trial = {r_rem, r_dvd[DW-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? VW'(w_trial - {1'b0, r_dvs}) : w_trial[VW-1:0];
            r_dvd <= {r_dvd[DW-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;

endmodule

>>> hw/rtl/tss_back.sv
`timescale 1ns / 1ps

module tss_back #(
    parameter int MAX_ROWS  = tss_pkg::MAX_ROWS,
    parameter int FRAC_BITS = tss_pkg::FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tss_pkg::t_queue_head  i_head,
    output logic                  o_pop,
    tss_sol_if.source             o_sol
);

    localparam int DW  = tss_pkg::DATA_W;
    localparam int AW  = $clog2(MAX_ROWS);
    localparam int IW  = tss_pkg::IDX_W;
    localparam int DVW = DW + FRAC_BITS;

    tss_pkg::t_state         r_state, n_state;
    tss_pkg::t_row           r_row, n_row;
    logic signed [DW-1:0]    r_prev_p, n_prev_p;
    logic signed [DW-1:0]    r_prev_q, n_prev_q;
    logic signed [63:0]      r_prod_p, n_prod_p;
    logic signed [63:0]      r_prod_q, n_prod_q;
    logic signed [DW-1:0]    r_den, n_den;
    logic signed [DW-1:0]    r_qnum, n_qnum;
    logic                    r_den_zero, n_den_zero;
    logic                    r_neg_p, n_neg_p;
    logic                    r_neg_q, n_neg_q;
    logic                    r_err, n_err;
    logic [AW-1:0]           r_k, n_k;
    logic signed [DW-1:0]    r_x, n_x;
    logic                    r_out_valid, n_out_valid;
    logic signed [DW-1:0]    r_out_value, n_out_value;
    logic [IW-1:0]           r_out_idx, n_out_idx;
    logic                    r_out_err, n_out_err;
    logic                    r_out_last, n_out_last;

    logic signed [DW-1:0]    r_mem_p [MAX_ROWS];
    logic signed [DW-1:0]    r_mem_q [MAX_ROWS];
    logic signed [DW-1:0]    r_rd_p;
    logic signed [DW-1:0]    r_rd_q;

    logic                    w_we;
    logic [AW-1:0]           w_waddr;
    logic signed [DW-1:0]    w_wp;
    logic signed [DW-1:0]    w_wq;

    logic                    w_start;
    logic [DVW-1:0]          w_dvd_p;
    logic [DVW-1:0]          w_dvd_q;
    logic [DW-1:0]           w_dvs;
    logic                    w_done_p;
    logic                    w_done_q;
    logic [DVW-1:0]          w_quot_p;
    logic [DVW-1:0]          w_quot_q;

    logic signed [DW:0]      w_num_p;
    logic signed [DW:0]      w_mag_p;
    logic signed [DW:0]      w_mag_q;
    logic signed [DW:0]      w_mag_d;
    logic signed [63:0]      w_sh_p;
    logic signed [63:0]      w_sh_q;
    logic signed [64:0]      w_sum_a;
    logic signed [64:0]      w_sum_b;
    logic [DW:0]             w_sat_a;
    logic [DW:0]             w_sat_b;
    logic [DW-1:0]           w_res_p;
    logic [DW-1:0]           w_res_q;
    logic                    w_ovf_p;
    logic                    w_ovf_q;
    logic [DVW-1:0]          w_lim;

    tss_div #(.DW(DVW), .VW(DW)) u_div_p (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dvd_p),
        .i_divisor  (w_dvs),
        .o_done     (w_done_p),
        .o_quot     (w_quot_p)
    );

    tss_div #(.DW(DVW), .VW(DW)) u_div_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dvd_q),
        .i_divisor  (w_dvs),
        .o_done     (w_done_q),
        .o_quot     (w_quot_q)
    );

    // operand magnitudes for the dividers
    assign w_num_p = -(DW+1)'(r_row.upper);
    assign w_mag_p = w_num_p[DW] ? -w_num_p : w_num_p;
    assign w_mag_q = r_qnum[DW-1] ? -(DW+1)'(r_qnum) : (DW+1)'(r_qnum);
    assign w_mag_d = r_den[DW-1] ? -(DW+1)'(r_den) : (DW+1)'(r_den);
    assign w_dvd_p = {w_mag_p[DW-1:0], {FRAC_BITS{1'b0}}};
    assign w_dvd_q = {w_mag_q[DW-1:0], {FRAC_BITS{1'b0}}};
    assign w_dvs   = w_mag_d[DW-1:0];

    // floor shift of the products
    assign w_sh_p = r_prod_p >>> FRAC_BITS;
    assign w_sh_q = r_prod_q >>> FRAC_BITS;

    // saturate quotient magnitudes back to signed 32 bits
    assign w_lim = DVW'({1'b1, {(DW-1){1'b0}}});
    always_comb begin
        if (r_neg_p) begin
            w_ovf_p = (w_quot_p > w_lim);
            w_res_p = w_ovf_p ? {1'b1, {(DW-1){1'b0}}} : -w_quot_p[DW-1:0];
        end else begin
            w_ovf_p = (w_quot_p >= w_lim);
            w_res_p = w_ovf_p ? {1'b0, {(DW-1){1'b1}}} : w_quot_p[DW-1:0];
        end
        if (r_neg_q) begin
            w_ovf_q = (w_quot_q > w_lim);
            w_res_q = w_ovf_q ? {1'b1, {(DW-1){1'b0}}} : -w_quot_q[DW-1:0];
        end else begin
            w_ovf_q = (w_quot_q >= w_lim);
            w_res_q = w_ovf_q ? {1'b0, {(DW-1){1'b1}}} : w_quot_q[DW-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_prev_p    = r_prev_p;
        n_prev_q    = r_prev_q;
        n_prod_p    = r_prod_p;
        n_prod_q    = r_prod_q;
        n_den       = r_den;
        n_qnum      = r_qnum;
        n_den_zero  = r_den_zero;
        n_neg_p     = r_neg_p;
        n_neg_q     = r_neg_q;
        n_err       = r_err;
        n_k         = r_k;
        n_x         = r_x;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_idx   = r_out_idx;
        n_out_err   = r_out_err;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;
        w_start     = 1'b0;
        w_we        = 1'b0;
        w_waddr     = AW'(r_row.idx);
        w_wp        = '0;
        w_wq        = '0;
        w_sum_a     = 65'(w_sh_p) + 65'(r_row.diag);
        w_sum_b     = 65'(r_row.rhs) - 65'(w_sh_q);
        w_sat_a     = tss_pkg::sat_wide(w_sum_a);
        w_sat_b     = tss_pkg::sat_wide(w_sum_b);

        unique case (r_state)
            tss_pkg::ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_row   = i_head.row;
                    n_state = tss_pkg::ST_MUL;
                end
            end
            tss_pkg::ST_MUL: begin
                n_prod_p = r_row.lower * r_prev_p;
                n_prod_q = r_row.lower * r_prev_q;
                n_state  = tss_pkg::ST_SUM;
            end
            tss_pkg::ST_SUM: begin
                if (r_row.idx == '0) begin
                    n_den  = r_row.diag;
                    n_qnum = r_row.rhs;
                end else begin
                    n_den  = w_sat_a[DW-1:0];
                    n_qnum = w_sat_b[DW-1:0];
                    n_err  = r_err | w_sat_a[DW] | w_sat_b[DW];
                end
                n_state = tss_pkg::ST_START;
            end
            tss_pkg::ST_START: begin
                w_start    = 1'b1;
                n_den_zero = (r_den == '0);
                n_neg_p    = w_num_p[DW] ^ r_den[DW-1];
                n_neg_q    = r_qnum[DW-1] ^ r_den[DW-1];
                n_state    = tss_pkg::ST_DIV;
            end
            tss_pkg::ST_DIV: begin
                if (w_done_p && w_done_q) begin
                    n_state = tss_pkg::ST_STORE;
                end
            end
            tss_pkg::ST_STORE: begin
                w_we = 1'b1;
                if (r_den_zero) begin
                    w_wp  = '0;
                    w_wq  = '0;
                    n_err = 1'b1;
                end else begin
                    w_wp  = r_row.last ? '0 : w_res_p;
                    w_wq  = w_res_q;
                    n_err = r_err | w_ovf_q | (w_ovf_p & ~r_row.last);
                end
                n_prev_p = w_wp;
                n_prev_q = w_wq;
                if (r_row.last) begin
                    n_x         = w_wq;
                    n_k         = AW'(r_row.idx);
                    n_out_valid = 1'b1;
                    n_out_value = w_wq;
                    n_out_idx   = r_row.idx;
                    n_out_err   = n_err;
                    n_out_last  = (r_row.idx == '0);
                    n_state     = tss_pkg::ST_OUT;
                end else begin
                    n_state = tss_pkg::ST_IDLE;
                end
            end
            tss_pkg::ST_OUT: begin
                if (o_sol.ready) begin
                    n_out_valid = 1'b0;
                    if (r_k == '0) begin
                        n_err   = 1'b0;
                        n_state = tss_pkg::ST_IDLE;
                    end else begin
                        n_k     = r_k - 1'b1;
                        n_state = tss_pkg::ST_READ;
                    end
                end
            end
            tss_pkg::ST_READ: begin
                n_state = tss_pkg::ST_BMUL;
            end
            tss_pkg::ST_BMUL: begin
                n_prod_p = r_rd_p * r_x;
                n_state  = tss_pkg::ST_BADD;
            end
            tss_pkg::ST_BADD: begin
                w_sum_a     = 65'(w_sh_p) + 65'(r_rd_q);
                w_sat_a     = tss_pkg::sat_wide(w_sum_a);
                n_err       = r_err | w_sat_a[DW];
                n_x         = w_sat_a[DW-1:0];
                n_out_valid = 1'b1;
                n_out_value = w_sat_a[DW-1:0];
                n_out_idx   = IW'(r_k);
                n_out_err   = n_err;
                n_out_last  = (r_k == '0);
                n_state     = tss_pkg::ST_OUT;
            end
            default: begin
                n_state = tss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tss_pkg::ST_IDLE;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row       <= n_row;
        r_prev_p    <= n_prev_p;
        r_prev_q    <= n_prev_q;
        r_prod_p    <= n_prod_p;
        r_prod_q    <= n_prod_q;
        r_den       <= n_den;
        r_qnum      <= n_qnum;
        r_den_zero  <= n_den_zero;
        r_neg_p     <= n_neg_p;
        r_neg_q     <= n_neg_q;
        r_k         <= n_k;
        r_x         <= n_x;
        r_out_value <= n_out_value;
        r_out_idx   <= n_out_idx;
        r_out_err   <= n_out_err;
        r_out_last  <= n_out_last;
    end

    // sweep coefficient stores
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem_p[w_waddr] <= w_wp;
            r_mem_q[w_waddr] <= w_wq;
        end
        r_rd_p <= r_mem_p[r_k];
        r_rd_q <= r_mem_q[r_k];
    end

    assign o_sol.valid          = r_out_valid;
    assign o_sol.solution_value = r_out_value;
    assign o_sol.solution_index = r_out_idx;
    assign o_sol.pivot_error    = r_out_err;
    assign o_sol.last_result    = r_out_last;

endmodule

>>> hw/rtl/tridiagonal_system_solver_core.sv
`timescale 1ns / 1ps
// Channel  Dir  Payload                                              Transfer
// i_row    in   lower/diag/upper_coeff, rhs_value (Q16.16), last_row valid & ready
// o_sol    out  solution_value, solution_index, pivot_error,         valid & ready
//               last_result
//
// In the back end each row waits on the bit-serial dividers (48 steps, P and Q
// divided side by side), so the dividers set the row rate. Back substitution
// computes each further result through ST_READ, ST_BMUL and ST_BADD, then
// waits in ST_OUT on any output stall.
// Reset is synchronous; the sweep stores need no clearing pass.
// Two rows queue in the front end while the back end works or stalls on o_sol.

module tridiagonal_system_solver_core #(
    parameter int MAX_ROWS  = tss_pkg::MAX_ROWS,
    parameter int FRAC_BITS = tss_pkg::FRAC_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tss_row_if.sink    i_row,
    tss_sol_if.source  o_sol
);

    tss_pkg::t_queue_head w_head;
    logic                 w_pop;

    tss_front #(.MAX_ROWS(MAX_ROWS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_row   (i_row),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    tss_back #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_sol   (o_sol)
    );

endmodule

>>> hw/rtl/tss_chk.sv
`timescale 1ns / 1ps

module tss_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [tss_pkg::DATA_W-1:0]    i_value,
    input logic [tss_pkg::IDX_W-1:0]     i_idx,
    input logic                          i_err,
    input logic                          i_last
);

    logic                        r_mid;
    logic [tss_pkg::IDX_W-1:0]   r_prev_idx;
    logic                        r_prev_err;

    // track the previous result transfer of a run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid      <= 1'b0;
            r_prev_idx <= '0;
            r_prev_err <= 1'b0;
        end else if (i_out_valid && i_out_ready) begin
            r_mid      <= !i_last;
            r_prev_idx <= i_idx;
            r_prev_err <= i_err;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_value) && $stable(i_idx)
            && $stable(i_err) && $stable(i_last))
        else $error("result changed while stalled");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last == (i_idx == '0)))
        else $error("end of run flag does not match index zero");

    a_desc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_mid |-> (i_idx == r_prev_idx - 1'b1))
        else $error("result index did not descend by one");

    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_mid && r_prev_err |-> i_err)
        else $error("error flag dropped inside a run");

endmodule

bind tridiagonal_system_solver_core tss_chk u_tss_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_sol.valid),
    .i_out_ready (o_sol.ready),
    .i_value     (o_sol.solution_value),
    .i_idx       (o_sol.solution_index),
    .i_err       (o_sol.pivot_error),
    .i_last      (o_sol.last_result)
);

>>> sim/tridiagonal_system_solver_core_checker.sv
`timescale 1ns / 1ps

module tridiagonal_system_solver_core_checker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tss_row_if.sink   i_row_mon,
    tss_sol_if.sink   i_sol_mon,
    output int        o_fail_count,
    output int        o_pending
);

    typedef struct packed {
        logic signed [tss_pkg::DATA_W-1:0] value;
        logic [tss_pkg::IDX_W-1:0]         index;
        logic                              err;
        logic                              last;
    } t_solution;

    logic signed [tss_pkg::DATA_W-1:0] p_coef[tss_pkg::MAX_ROWS];
    logic signed [tss_pkg::DATA_W-1:0] q_coef[tss_pkg::MAX_ROWS];
    int unsigned                       rows_taken;
    bit                                err_flag;
    t_solution                         solution_q[$];

    assign o_pending = solution_q.size();

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) begin
            err_flag = 1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            err_flag = 1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // floor shift of the full product
    function automatic longint fx_mul(longint a, longint b);
        return (a * b) >>> tss_pkg::FRAC_BITS;
    endfunction

    function automatic longint fx_div(longint num, longint den);
        if (den == 0) begin
            err_flag = 1;
            return 0;
        end
        return clamp32((num * (64'sd1 << tss_pkg::FRAC_BITS)) / den);
    endfunction

    task automatic solve_row(longint lo, longint di, longint up, longint rh, bit last_in);
        int unsigned idx;
        bit          last;
        longint      den;
        longint      num;
        longint      x;
        t_solution   s;
        idx  = rows_taken;
        last = last_in || (idx >= tss_pkg::MAX_ROWS - 1);
        if (idx >= tss_pkg::MAX_ROWS) begin
            idx  = tss_pkg::MAX_ROWS - 1;
            last = 1;
        end
        if (idx == 0) begin
            den = di;
            num = rh;
        end else begin
            den = clamp32(di + fx_mul(lo, p_coef[idx-1]));
            num = clamp32(rh - fx_mul(lo, q_coef[idx-1]));
        end
        p_coef[idx] = last ? 0 : fx_div(-up, den);
        q_coef[idx] = fx_div(num, den);
        if (!last) begin
            rows_taken = idx + 1;
            return;
        end
        x = q_coef[idx];
        for (int k = idx; k >= 0; k--) begin
            if (k != idx) x = clamp32(fx_mul(p_coef[k], x) + q_coef[k]);
            s.value = x[tss_pkg::DATA_W-1:0];
            s.index = k[tss_pkg::IDX_W-1:0];
            s.err   = err_flag;
            s.last  = (k == 0);
            solution_q.push_back(s);
        end
        rows_taken = 0;
        err_flag   = 0;
    endtask

    always @(posedge i_clk) begin
        t_solution e;
        if (!i_rst_n) begin
            rows_taken   <= 0;
            err_flag     <= 0;
            o_fail_count <= 0;
        end else begin
            if (i_sol_mon.valid && i_sol_mon.ready) begin
                if (solution_q.size() == 0) begin
                    $display("%0t: unexpected result value=%h index=%0d", $time,
                             i_sol_mon.solution_value, i_sol_mon.solution_index);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = solution_q.pop_front();
                    if (e.value !== i_sol_mon.solution_value
                            || e.index !== i_sol_mon.solution_index
                            || e.err !== i_sol_mon.pivot_error
                            || e.last !== i_sol_mon.last_result) begin
                        $display("%0t: mismatch expected v=%h i=%0d e=%b l=%b",
                                 $time, e.value, e.index, e.err, e.last);
                        $display("%0t:          actual   v=%h i=%0d e=%b l=%b",
                                 $time, i_sol_mon.solution_value,
                                 i_sol_mon.solution_index,
                                 i_sol_mon.pivot_error, i_sol_mon.last_result);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_row_mon.valid && i_row_mon.ready)
                solve_row(i_row_mon.lower_coeff, i_row_mon.diag_coeff,
                          i_row_mon.upper_coeff, i_row_mon.rhs_value, i_row_mon.last_row);
        end
    end
endmodule

>>> sim/tridiagonal_system_solver_core_tb.sv
`timescale 1ns / 1ps

module tridiagonal_system_solver_core_tb;
    localparam int LIMIT = 3_000_000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;
    bit   hold_req;
    bit   hold_seen;
    bit   stim_done;

    tss_row_if row_ch ();
    tss_sol_if sol_ch ();

    tridiagonal_system_solver_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_row   (row_ch.sink),
        .o_sol   (sol_ch.source)
    );

    tridiagonal_system_solver_core_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_row_mon    (row_ch.sink),
        .i_sol_mon    (sol_ch.sink),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        row_ch.valid = 0;
        row_ch.lower_coeff = 0;
        row_ch.diag_coeff = 0;
        row_ch.upper_coeff = 0;
        row_ch.rhs_value = 0;
        row_ch.last_row = 0;
        sol_ch.ready = 0;
        i_rst_n = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("tridiagonal_system_solver_core_tb: FAIL");
            $finish;
        end
    end
    initial cycle_count = 0;

    // stall pattern, with one long hold-off counted here once requested
    initial begin
        int phase;
        int hold_left;
        phase = 0;
        hold_left = 0;
        hold_seen = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            phase++;
            if (hold_req && !hold_seen) begin
                hold_seen = 1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                sol_ch.ready <= 0;
            end
            else if ((phase / 50) % 3 == 0) sol_ch.ready <= 1;
            else sol_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send_row(logic [31:0] lo, logic [31:0] di, logic [31:0] up,
                            logic [31:0] rh, bit last);
        row_ch.valid       <= 1;
        row_ch.lower_coeff <= lo;
        row_ch.diag_coeff  <= di;
        row_ch.upper_coeff <= up;
        row_ch.rhs_value   <= rh;
        row_ch.last_row    <= last;
        do @(posedge i_clk); while (!row_ch.ready);
        if ($urandom_range(0, 3) == 0) begin
            row_ch.valid <= 0;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            2: return 0;
            default: return $urandom_range(0, 1) ? $urandom_range(0, 32'h0004_0000)
                                                 : -$urandom_range(0, 32'h0004_0000);
        endcase
    endfunction

    // diagonally dominant row so the sweep stays well behaved
    function automatic logic [31:0] dom_diag();
        logic [31:0] d;
        d = $urandom_range(32'h0003_0000, 32'h0010_0000);
        return $urandom_range(0, 1) ? d : -d;
    endfunction

    initial begin
        int n;
        int sent;
        hold_req = 0;
        stim_done = 0;
        wait (i_rst_n);
        @(posedge i_clk);
        // directed: single rows, short systems, zero pivot, extremes, overflow
        send_row(0, 32'h0002_0000, 0, 32'h0006_0000, 1);
        send_row(32'hffffffff, 0, 32'hffffffff, 32'h0001_0000, 1);
        send_row(0, 32'h0000_0001, 0, 32'h7fffffff, 1);
        send_row(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1);
        send_row(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1);
        send_row(0, 32'h0004_0000, 32'h0001_0000, 32'h0001_0000, 0);
        send_row(32'h0001_0000, 32'h0004_0000, 32'h0001_0000, 32'h0002_0000, 0);
        send_row(32'h0001_0000, 32'h0004_0000, 0, 32'h0003_0000, 1);
        send_row(0, 32'h0001_0000, 32'h0001_0000, 1, 0);
        send_row(32'h0001_0000, 32'h0001_0000, 0, 2, 1);          // zero pivot on row 1
        send_row(0, 32'h0000_0100, 32'h7fff_0000, 5, 0);           // P saturates
        send_row(32'h7fffffff, 32'h0001_0000, 0, 32'h7fffffff, 1);
        // overlong system: row 63 ends the run without last_row
        for (int k = 0; k < 64; k++)
            send_row($urandom, dom_diag(), $urandom_range(0, 32'h0001_0000),
                     $urandom, 0);
        sent = 0;
        while (sent < 40) begin
            if (!hold_req && sent >= 10) begin
                // single-row systems keep coming while results are held off
                hold_req = 1;
                for (int k = 0; k < 6; k++)
                    send_row(0, dom_diag(), 0, $urandom, 1);
                sent += 6;
            end
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
            if (n > 40 - sent) n = 40 - sent;
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 4) == 0)
                    send_row(rand_val(), rand_val(), rand_val(), rand_val(), k == n - 1);
                else
                    send_row($urandom_range(0, 32'h0001_0000), dom_diag(),
                             -$urandom_range(0, 32'h0001_0000), $urandom, k == n - 1);
                sent++;
            end
        end
        row_ch.valid <= 0;
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tridiagonal_system_solver_core_tb: PASS");
        else
            $display("tridiagonal_system_solver_core_tb: FAIL");
        $finish;
    end
endmodule
